// ===== src/irpw_pkg.sv =====
// Shared types and constants for the IR pulse-width transmitter.
`timescale 1ns / 1ps
package irpw_pkg;

  localparam int MAX_BITS = 20;
  localparam int CODE_W   = 20;
  localparam int BITS_W   = 5;
  localparam int REPS_W   = 4;
  localparam int PERIOD_W = 16;
  localparam int LEN_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_REPEATS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MARK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MARK     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE         = 3'd6;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef struct packed {
    logic              func;
    logic [CODE_W-1:0] code;
  } in_beat_t;

  typedef struct packed {
    logic ir_out;
    logic busy_res;
    logic start_taken;
  } out_beat_t;

  typedef struct packed {
    logic              is_start;
    logic [CODE_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [BITS_W-1:0]   bit_count;
    logic [REPS_W-1:0]   frame_repeats;
    logic [PERIOD_W-1:0] frame_period_ticks;
    logic [LEN_W-1:0]    leader_ticks;
    logic [LEN_W-1:0]    one_mark_ticks;
    logic [LEN_W-1:0]    zero_mark_ticks;
    logic [LEN_W-1:0]    space_ticks;
  } cfg_regs_t;

endpackage

// ===== src/irpw_front.sv =====
// Front end: classify input beats and queue them for the sequencer.
`timescale 1ns / 1ps
module irpw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  irpw_pkg::in_beat_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output irpw_pkg::cmd_t    q_data
);
  import irpw_pkg::*;

  cmd_t              q_mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] q_count_r, q_count_nxt;
  logic              push;
  logic              pop;
  cmd_t              cmd;

  assign in_stall = (q_count_r == QCNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_data   = q_mem[rd_ptr_r];

  always_comb begin
    cmd.is_start = (in_data.func == FUNC_START);
    cmd.code     = in_data.code;
  end

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    q_count_nxt = q_count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      q_count_nxt = q_count_r + 1'b1;
    end else if (pop && !push) begin
      q_count_nxt = q_count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_count_r <= '0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      q_count_r <= q_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= QCNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      (q_count_r == $past(q_count_r) + QCNT_W'($past(push)) - QCNT_W'($past(pop))))
    else $error("queue count does not follow push and pop");

endmodule

// ===== src/irpw_back.sv =====
// Back end: frame sequencer and registered result stage.
`timescale 1ns / 1ps
module irpw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  irpw_pkg::cfg_regs_t cfg,
  input  logic                q_valid,
  output logic                q_pop,
  input  irpw_pkg::cmd_t      q_data,
  output logic                out_valid,
  input  logic                out_stall,
  output irpw_pkg::out_beat_t out_data
);
  import irpw_pkg::*;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_LEADER    = 3'd1;
  localparam logic [2:0] PH_LEADSPACE = 3'd2;
  localparam logic [2:0] PH_MARK      = 3'd3;
  localparam logic [2:0] PH_SPACE     = 3'd4;
  localparam logic [2:0] PH_GAP       = 3'd5;

  logic [2:0]          phase_r, phase_nxt;
  logic [LEN_W-1:0]    seg_r, seg_nxt;
  logic [PERIOD_W-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [BITS_W-1:0]   bit_idx_r, bit_idx_nxt;
  logic [REPS_W-1:0]   frames_sent_r, frames_sent_nxt;
  logic [CODE_W-1:0]   code_hold_r, code_hold_nxt;
  logic                carrier_r, carrier_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_data_r, res;

  logic [BITS_W-1:0]   eff_bits;
  logic [REPS_W-1:0]   reps;
  logic                cur_bit;
  logic [LEN_W-1:0]    seg_len_raw;
  logic [LEN_W-1:0]    seg_len;
  logic [LEN_W-1:0]    seg_inc;
  logic [BITS_W-1:0]   bit_inc;
  logic [REPS_W-1:0]   fs_inc;
  logic                pop;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = pop;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign eff_bits = (cfg.bit_count > BITS_W'(MAX_BITS)) ? BITS_W'(MAX_BITS) : cfg.bit_count;
  assign reps     = (cfg.frame_repeats == '0) ? REPS_W'(1) : cfg.frame_repeats;
  assign cur_bit  = (bit_idx_r >= BITS_W'(CODE_W)) ? 1'b0 : code_hold_r[bit_idx_r];
  assign seg_inc  = seg_r + 1'b1;
  assign bit_inc  = bit_idx_r + 1'b1;
  assign fs_inc   = frames_sent_r + 1'b1;

  always_comb begin
    unique case (phase_r)
      PH_LEADER: seg_len_raw = cfg.leader_ticks;
      PH_MARK:   seg_len_raw = cur_bit ? cfg.one_mark_ticks : cfg.zero_mark_ticks;
      default:   seg_len_raw = cfg.space_ticks;
    endcase
    seg_len = (seg_len_raw == '0) ? LEN_W'(1) : seg_len_raw;
  end

  always_comb begin
    phase_nxt       = phase_r;
    seg_nxt         = seg_r;
    frame_cnt_nxt   = frame_cnt_r;
    bit_idx_nxt     = bit_idx_r;
    frames_sent_nxt = frames_sent_r;
    code_hold_nxt   = code_hold_r;
    carrier_nxt     = carrier_r;
    res             = '0;

    if (q_data.is_start) begin
      if (phase_r == PH_IDLE) begin
        code_hold_nxt   = q_data.code;
        frames_sent_nxt = '0;
        phase_nxt       = PH_LEADER;
        seg_nxt         = '0;
        frame_cnt_nxt   = '0;
        bit_idx_nxt     = '0;
        res.start_taken = 1'b1;
      end
      res.ir_out   = carrier_r;
      res.busy_res = 1'b1;
    end else if (phase_r != PH_IDLE) begin
      res.busy_res = 1'b1;
      if (phase_r == PH_LEADER || phase_r == PH_MARK) begin
        res.ir_out = ~seg_r[0];
      end
      carrier_nxt = res.ir_out;
      if (frame_cnt_r != '1) begin
        frame_cnt_nxt = frame_cnt_r + 1'b1;
      end
      if (phase_r != PH_GAP) begin
        seg_nxt = seg_inc;
        if (seg_inc >= seg_len) begin
          seg_nxt = '0;
          unique case (phase_r)
            PH_LEADER: phase_nxt = PH_LEADSPACE;
            PH_MARK:   phase_nxt = PH_SPACE;
            PH_LEADSPACE: begin
              bit_idx_nxt = '0;
              if (eff_bits == '0) begin
                frames_sent_nxt = fs_inc;
                phase_nxt = (fs_inc >= reps) ? PH_IDLE : PH_GAP;
              end else begin
                phase_nxt = PH_MARK;
              end
            end
            default: begin
              bit_idx_nxt = bit_inc;
              if (bit_inc < eff_bits) begin
                phase_nxt = PH_MARK;
              end else begin
                frames_sent_nxt = fs_inc;
                phase_nxt = (fs_inc >= reps) ? PH_IDLE : PH_GAP;
              end
            end
          endcase
        end
      end
      if (phase_nxt == PH_GAP && frame_cnt_nxt >= cfg.frame_period_ticks) begin
        phase_nxt     = PH_LEADER;
        seg_nxt       = '0;
        frame_cnt_nxt = '0;
        bit_idx_nxt   = '0;
      end
    end else begin
      carrier_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      seg_r         <= '0;
      frame_cnt_r   <= '0;
      bit_idx_r     <= '0;
      frames_sent_r <= '0;
      code_hold_r   <= '0;
      carrier_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r       <= phase_nxt;
        seg_r         <= seg_nxt;
        frame_cnt_r   <= frame_cnt_nxt;
        bit_idx_r     <= bit_idx_nxt;
        frames_sent_r <= frames_sent_nxt;
        code_hold_r   <= code_hold_nxt;
        carrier_r     <= carrier_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

  a_quiet_low: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_GAP) |-> !carrier_r)
    else $error("pin level high outside a mark");

  a_mark_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MARK) |-> (bit_idx_r < BITS_W'(MAX_BITS)))
    else $error("bit index past the last code bit during a mark");

  a_taken_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.start_taken) |-> out_data_r.busy_res)
    else $error("accepted start reported as not busy");

endmodule

// ===== src/ir_remote_pulse_width_transmitter.sv =====
// Top level of the IR pulse-width transmitter: configuration registers and datapath.
`timescale 1ns / 1ps
// Takes one beat per clock when not stalled and returns one result beat per input
// beat, in order. A beat passes through the two-entry input queue; the frame
// sequencer then updates its state and registers the result as it pops the beat.
// The result sits in the output register until taken, while the queue takes up to
// two more beats before it stalls the input. A tick beat advances the frame timing
// by one tick; a start beat loads a code when idle and never advances time. Write
// configuration only while no beat is in flight.
module ir_remote_pulse_width_transmitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  irpw_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output irpw_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [irpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irpw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import irpw_pkg::*;

  cfg_regs_t cfg_r;
  logic      q_valid;
  logic      q_pop;
  cmd_t      q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_count          <= BITS_W'(12);
      cfg_r.frame_repeats      <= REPS_W'(3);
      cfg_r.frame_period_ticks <= PERIOD_W'(3750);
      cfg_r.leader_ticks       <= LEN_W'(200);
      cfg_r.one_mark_ticks     <= LEN_W'(100);
      cfg_r.zero_mark_ticks    <= LEN_W'(50);
      cfg_r.space_ticks        <= LEN_W'(50);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_COUNT:     cfg_r.bit_count          <= cfg_wdata[BITS_W-1:0];
        REG_FRAME_REPEATS: cfg_r.frame_repeats      <= cfg_wdata[REPS_W-1:0];
        REG_FRAME_PERIOD:  cfg_r.frame_period_ticks <= cfg_wdata[PERIOD_W-1:0];
        REG_LEADER:        cfg_r.leader_ticks       <= cfg_wdata[LEN_W-1:0];
        REG_ONE_MARK:      cfg_r.one_mark_ticks     <= cfg_wdata[LEN_W-1:0];
        REG_ZERO_MARK:     cfg_r.zero_mark_ticks    <= cfg_wdata[LEN_W-1:0];
        REG_SPACE:         cfg_r.space_ticks        <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  irpw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  irpw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
